@@ design/hwc_pkg.sv @@
package hwc_pkg;

  // output queue geometry
  localparam int unsigned Q_DEPTH = 16;
  localparam int unsigned Q_IDX_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // marker lengths and held-prefix counter width
  localparam int unsigned OFF_LEN = 13;
  localparam int unsigned ON_LEN  = 12;
  localparam int unsigned ML_W    = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // one queued output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hwc_entry_t;

  // per-cycle command broadcast to every queue cell
  typedef struct packed {
    logic               pop;
    logic               mark_en;
    logic [Q_IDX_W-1:0] mark_idx;
    logic               wr0_en;
    logic [Q_IDX_W-1:0] wr0_idx;
    hwc_entry_t         wr0_ent;
    logic               wr1_en;
    logic [Q_IDX_W-1:0] wr1_idx;
    hwc_entry_t         wr1_ent;
  } hwc_qctl_t;

  // what the parser does with the accepted byte
  typedef struct packed {
    logic push_sp;
    logic push_b;
    logic b_last;
    logic mark_tail;
    logic drop;
  } hwc_act_t;

  // folded character of SC_OFF (off = 1) or SC_ON (off = 0) at a position
  function automatic logic [7:0] mark_char(input logic off, input logic [ML_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h3C;                 // <
      4'd1:    c = 8'h21;                 // !
      4'd2:    c = 8'h2D;                 // -
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h53;                 // S
      4'd5:    c = 8'h43;                 // C
      4'd6:    c = 8'h5F;                 // _
      4'd7:    c = 8'h4F;                 // O
      4'd8:    c = off ? 8'h46 : 8'h4E;   // F / N
      4'd9:    c = off ? 8'h46 : 8'h2D;   // F / -
      4'd10:   c = 8'h2D;
      4'd11:   c = off ? 8'h2D : 8'h3E;   // - / >
      4'd12:   c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ design/hwc_cell.sv @@
module hwc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  hwc_pkg::hwc_qctl_t ctl_i,
  input  hwc_pkg::hwc_entry_t right_i,
  output hwc_pkg::hwc_entry_t ent_o
);
  import hwc_pkg::*;

  localparam logic [Q_IDX_W-1:0] MyIdx = Q_IDX_W'(IDX);

  hwc_entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ctl_i.pop ? right_i : ent_q;
    if (ctl_i.mark_en && ctl_i.mark_idx == MyIdx) begin
      ent_d.last = 1'b1;
    end
    if (ctl_i.wr0_en && ctl_i.wr0_idx == MyIdx) begin
      ent_d = ctl_i.wr0_ent;
    end
    if (ctl_i.wr1_en && ctl_i.wr1_idx == MyIdx) begin
      ent_d = ctl_i.wr1_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

@@ design/hwc_ctrl.sv @@
module hwc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic                      strip_en_i,
  output hwc_pkg::hwc_act_t         act_o,
  output logic [hwc_pkg::ML_W-1:0]  ml_o
);
  import hwc_pkg::*;

  logic            comp_q, comp_d;
  logic            sp_q, sp_d;
  logic            acb_q, acb_d;
  logic [ML_W-1:0] ml_q, ml_d;

  logic [7:0]      folded;
  logic [ML_W-1:0] len_m1;
  logic [ML_W-1:0] ml_eff;
  logic            fits0, mismatch, fits, complete, hold, is_ws;

  always_comb begin
    folded   = (byte_i >= CH_LO_A && byte_i <= CH_LO_Z) ? byte_i - CASE_OFS : byte_i;
    len_m1   = comp_q ? ML_W'(OFF_LEN - 1) : ML_W'(ON_LEN - 1);
    fits0    = folded == mark_char(comp_q, ml_q);
    mismatch = (ml_q != '0) && !fits0;
    ml_eff   = mismatch ? '0 : ml_q;
    fits     = mismatch ? (folded == CH_LT) : fits0;
    complete = fits && ml_eff == len_m1;
    hold     = fits && !complete;
    is_ws    = byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_CR || byte_i == CH_LF;
  end

  // next state
  always_comb begin
    comp_d = comp_q;
    sp_d   = sp_q;
    acb_d  = acb_q;
    ml_d   = ml_q;
    if (accept_i) begin
      if (!strip_en_i) begin
        ml_d  = '0;
        sp_d  = 1'b0;
        acb_d = 1'b0;
      end else begin
        ml_d = ml_eff;
        if (complete) begin
          comp_d = !comp_q;
          ml_d   = '0;
          sp_d   = 1'b0;
          acb_d  = 1'b0;
        end else if (hold) begin
          if (comp_q && ml_eff == '0) begin
            sp_d  = 1'b0;
            acb_d = 1'b0;
          end
          ml_d = ml_eff + 1'b1;
        end else if (comp_q) begin
          if (is_ws) begin
            if (!acb_q) begin
              sp_d = 1'b1;
            end
          end else begin
            sp_d  = 1'b0;
            acb_d = byte_i == CH_GT;
          end
        end
        if (last_i) begin
          ml_d  = '0;
          sp_d  = 1'b0;
          acb_d = 1'b0;
        end
      end
    end
  end

  // actions on the output queue
  always_comb begin
    logic commit_old;
    act_o = '0;
    commit_old = (ml_q != '0) && (!strip_en_i || mismatch || (last_i && !complete));
    if (accept_i) begin
      if (!strip_en_i) begin
        act_o.push_b = 1'b1;
      end else begin
        act_o.drop    = complete;
        act_o.push_b  = hold || (!complete && !(comp_q && is_ws));
        act_o.push_sp = !fits && comp_q && !is_ws && sp_q && byte_i != CH_LT;
      end
      act_o.b_last    = act_o.push_b && (!(strip_en_i && hold) || last_i);
      act_o.mark_tail = commit_old && !act_o.b_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= 1'b1;
      sp_q   <= 1'b0;
      acb_q  <= 1'b0;
      ml_q   <= '0;
    end else begin
      comp_q <= comp_d;
      sp_q   <= sp_d;
      acb_q  <= acb_d;
      ml_q   <= ml_d;
    end
  end

  assign ml_o = ml_q;

endmodule

@@ design/html_whitespace_collapser_unit.sv @@
// html whitespace collapser: takes one html body byte per transfer on the
// slave stream (tlast marks the last byte of a buffer) and gives the stripped
// bytes on the master stream (tlast marks the last byte caused by an input
// byte). with strip enabled, whitespace runs fold to one space (dropped before
// '<', after '>' and at buffer ends), and <!--SC_OFF--> / <!--SC_ON--> markers
// are removed and toggle pass-through. rate: one input byte per cycle while the
// queue has room and one output byte per cycle while the sink is ready and a
// final (not held) byte is queued. results sit in a 16-cell shift queue that
// also holds up to 12 bytes of a possible marker; input is taken while at
// least two cells are free, so a stalled output side eventually stops input.
// the config write channel is always ready and is meant to be written idle.
module html_whitespace_collapser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write channel: strip_enable in bit 0
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // buffer_end
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // run_last
);
  import hwc_pkg::*;

  logic               strip_q;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               in_xfer, pop;
  hwc_act_t           act;
  logic [ML_W-1:0]    ml;
  logic [Q_CNT_W-1:0] ml_ext, wpos0, tail_pos;
  hwc_qctl_t          qctl;
  hwc_entry_t         cell_ent [Q_DEPTH];
  hwc_entry_t         right_ent [Q_DEPTH];

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
    end else if (cfg_valid_i) begin
      strip_q <= cfg_data_i;
    end
  end

  // room for a space plus the byte itself
  assign s_axis_tready = count_q <= Q_CNT_W'(Q_DEPTH - 2);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  hwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .strip_en_i (strip_q),
    .act_o      (act),
    .ml_o       (ml)
  );

  // held marker bytes are the youngest ml entries; older ones are final
  assign ml_ext        = Q_CNT_W'(ml);
  assign m_axis_tvalid = count_q > ml_ext;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = cell_ent[0].data;
  assign m_axis_tlast  = cell_ent[0].last;

  assign wpos0    = count_q - Q_CNT_W'(pop);
  assign tail_pos = wpos0 - 1'b1;

  always_comb begin
    qctl              = '0;
    qctl.pop          = pop;
    qctl.mark_en      = act.mark_tail;
    qctl.mark_idx     = tail_pos[Q_IDX_W-1:0];
    qctl.wr0_idx      = wpos0[Q_IDX_W-1:0];
    qctl.wr1_idx      = wpos0[Q_IDX_W-1:0] + 1'b1;
    if (act.push_sp) begin
      // space then the byte
      qctl.wr0_en       = 1'b1;
      qctl.wr0_ent.data = CH_SPACE;
      qctl.wr0_ent.last = 1'b0;
      qctl.wr1_en       = act.push_b;
      qctl.wr1_ent.data = s_axis_tdata;
      qctl.wr1_ent.last = act.b_last;
    end else begin
      qctl.wr0_en       = act.push_b;
      qctl.wr0_ent.data = s_axis_tdata;
      qctl.wr0_ent.last = act.b_last;
    end
  end

  // occupancy: a completed marker discards its held bytes
  always_comb begin
    count_d = count_q - Q_CNT_W'(pop) + Q_CNT_W'(act.push_sp) + Q_CNT_W'(act.push_b);
    if (act.drop) begin
      count_d = count_d - ml_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // queue cells, each shifting toward the head on a pop
  for (genvar g = 0; g < Q_DEPTH; g++) begin : g_cell
    if (g == Q_DEPTH - 1) begin : g_end
      assign right_ent[g] = '0;
    end else begin : g_mid
      assign right_ent[g] = cell_ent[g+1];
    end
    hwc_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (qctl),
      .right_i (right_ent[g]),
      .ent_o   (cell_ent[g])
    );
  end

`ifndef SYNTH
  a_held_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ml_ext <= count_q)
    else $error("held marker bytes exceed queue occupancy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ml <= ML_W'(OFF_LEN - 1))
    else $error("held prefix longer than a marker");

  a_bypass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !strip_q) |=> (ml == '0))
    else $error("held bytes left after a bypass transfer");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> (ml == '0))
    else $error("held bytes left after a buffer end");
`endif

endmodule
